// ----- rtl/nrt_pkg.sv -----
// ============================================================================
// Nonce replay table package
// Shared request and response types, cell control, states and constants.
// ============================================================================
package nrt_pkg;

    // Field widths fixed by the request and response formats.
    localparam int DIGEST_W = 64;
    localparam int TIME_W   = 48;
    localparam int TTL_W    = 32;
    localparam int CAP_W    = 7;
    localparam int INTV_W   = 10;
    localparam int OCNT_W   = 7;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_TTL  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CAP  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INTV = 2'd2;

    // Register reset values.
    localparam logic [TTL_W-1:0]  TTL_RST  = 32'd60000;
    localparam logic [CAP_W-1:0]  CAP_RST  = 7'd0;
    localparam logic [INTV_W-1:0] INTV_RST = 10'd1000;

    // Request actions.
    localparam logic ACT_CHECK = 1'b0;
    localparam logic ACT_SWEEP = 1'b1;

    typedef struct packed {
        logic                action;
        logic [DIGEST_W-1:0] fingerprint_digest;
        logic [DIGEST_W-1:0] nonce_digest;
        logic [TIME_W-1:0]   insert_time;
        logic [TIME_W-1:0]   now_time;
    } t_req;

    typedef struct packed {
        logic              fresh;
        logic              evicted;
        logic [OCNT_W-1:0] expired_count;
        logic [OCNT_W-1:0] entry_count;
    } t_rsp;

    // Control for one cell of the chain.
    typedef struct packed {
        logic load_new;  // take the new key from the broadcast bus
        logic shift;     // take the neighbor's contents (oldest drop)
        logic age;       // clear the valid flag if the entry has expired
        logic pack;      // close up a hole by taking the neighbor's contents
    } t_cell_ctl;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_AGE,
        ST_PACK
    } t_state;

endpackage

// ----- rtl/nrt_cell.sv -----
// ============================================================================
// Nonce replay table cell
// One table entry: digests, time stamp and flags, with neighbor hand-off.
// ============================================================================
module nrt_cell
    import nrt_pkg::*;
#(
    parameter int KEY_WIDTH = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cell_ctl            i_ctl,
    input  logic [KEY_WIDTH-1:0] i_key_fp,
    input  logic [KEY_WIDTH-1:0] i_key_nc,
    input  logic [TIME_W-1:0]    i_key_time,
    input  logic [TIME_W-1:0]    i_now,
    input  logic [TTL_W-1:0]     i_ttl,
    input  logic [KEY_WIDTH-1:0] i_nb_fp,
    input  logic [KEY_WIDTH-1:0] i_nb_nc,
    input  logic [TIME_W-1:0]    i_nb_time,
    input  logic                 i_nb_vld,
    input  logic                 i_nb_occ,
    input  logic                 i_hole,
    output logic [KEY_WIDTH-1:0] o_fp,
    output logic [KEY_WIDTH-1:0] o_nc,
    output logic [TIME_W-1:0]    o_time,
    output logic                 o_vld,
    output logic                 o_occ,
    output logic                 o_hole,
    output logic                 o_match
);

    logic [KEY_WIDTH-1:0] r_fp;
    logic [KEY_WIDTH-1:0] r_nc;
    logic [TIME_W-1:0]    r_time;
    logic                 r_vld;
    logic                 r_occ;
    logic [TIME_W:0]      w_age;
    logic                 w_expire;
    logic                 w_hole_seen;

    // Signed age: a time stamp later than now gives a negative age.
    assign w_age    = {1'b0, i_now} - {1'b0, r_time};
    assign w_expire = r_vld && !w_age[TIME_W] &&
                      (w_age[TIME_W-1:0] > TIME_W'(i_ttl));

    // A hole is a slot that held an entry before the sweep and lost it; the flag also passes up from any hole below.
    assign w_hole_seen = i_hole || (r_occ && !r_vld);

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_ctl.load_new) begin
            r_fp   <= i_key_fp;
            r_nc   <= i_key_nc;
            r_time <= i_key_time;
        end else if (i_ctl.shift || (i_ctl.pack && w_hole_seen)) begin
            r_fp   <= i_nb_fp;
            r_nc   <= i_nb_nc;
            r_time <= i_nb_time;
        end
    end

    // Flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
            r_occ <= 1'b0;
        end else if (i_ctl.load_new) begin
            r_vld <= 1'b1;
            r_occ <= 1'b1;
        end else if (i_ctl.shift || (i_ctl.pack && w_hole_seen)) begin
            r_vld <= i_nb_vld;
            r_occ <= i_nb_occ;
        end else if (i_ctl.age && w_expire) begin
            r_vld <= 1'b0;
        end
    end

    assign o_fp    = r_fp;
    assign o_nc    = r_nc;
    assign o_time  = r_time;
    assign o_vld   = r_vld;
    assign o_occ   = r_occ;
    assign o_hole  = w_hole_seen;
    assign o_match = r_vld && (r_fp == i_key_fp) && (r_nc == i_key_nc);

endmodule

// ----- rtl/nonce_replay_table_top.sv -----
// ============================================================================
// Nonce replay table
// Replay detector over an age-ordered chain of entry cells with expiry sweeps.
// ============================================================================
//
// Channel     Direction  Handshake                 Payload
// request     in         start & !busy             i_req (t_req)
// response    out        o_strobe, one cycle       o_rsp (t_rsp)
// config      in         i_cfg_valid & o_cfg_ready i_cfg_index, i_cfg_data
//
// A check does the parallel compare and insert, then the response register
// raises the strobe. A sweep request, and an automatic sweep after a check,
// first ages all cells at once, then closes up one hole in the chain per
// pack step, one for each expired entry, and ends with a step that sees
// that no hole is left.
// Reset is synchronous; it empties the table and loads the register defaults.
// The response cannot be stalled; busy stays high until the response cycle.
//
module nonce_replay_table_top
    import nrt_pkg::*;
#(
    parameter int DEPTH     = 64,
    parameter int KEY_WIDTH = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  t_req                 i_req,
    output logic                 o_strobe,
    output t_rsp                 o_rsp,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [TTL_W-1:0]     i_cfg_data
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int LIM_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    t_state               r_state, n_state;
    t_req                 r_req;
    logic [CNT_W-1:0]     r_count, n_count;
    logic [CNT_W-1:0]     r_exp, n_exp;
    logic [INTV_W-1:0]    r_ins, n_ins;
    logic                 r_fresh, n_fresh;
    logic                 r_evict, n_evict;
    logic                 r_strobe, n_strobe;
    t_rsp                 r_rsp, n_rsp;
    logic [TTL_W-1:0]     r_ttl;
    logic [CAP_W-1:0]     r_cap;
    logic [INTV_W-1:0]    r_intv;

    logic                 w_wr_en;
    logic                 w_shift;
    logic                 w_age;
    logic                 w_pack;
    logic [CNT_W-1:0]     w_wr_idx;
    logic [LIM_W-1:0]     w_cap_ext;
    logic [LIM_W-1:0]     w_limit;
    logic                 w_full;
    logic [INTV_W-1:0]    w_ins_nx;
    logic                 w_any_match;

    logic [KEY_WIDTH-1:0] w_fp   [DEPTH+1];
    logic [KEY_WIDTH-1:0] w_nc   [DEPTH+1];
    logic [TIME_W-1:0]    w_time [DEPTH+1];
    logic [DEPTH:0]       w_vld;
    logic [DEPTH:0]       w_occ;
    logic [DEPTH:0]       w_hole;
    logic [DEPTH-1:0]     w_match;
    t_cell_ctl            w_ctl  [DEPTH];

    // Configuration registers; writes are always taken.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ttl  <= TTL_RST;
            r_cap  <= CAP_RST;
            r_intv <= INTV_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_TTL:  r_ttl  <= i_cfg_data;
                CFG_CAP:  r_cap  <= i_cfg_data[CAP_W-1:0];
                CFG_INTV: r_intv <= i_cfg_data[INTV_W-1:0];
                default:  ;
            endcase
        end
    end

    // Effective limit: capacity zero or above the depth means the full depth.
    assign w_cap_ext = LIM_W'(r_cap);
    assign w_limit   = ((r_cap == '0) || (w_cap_ext > LIM_W'(DEPTH))) ?
                       LIM_W'(DEPTH) : w_cap_ext;
    assign w_full    = (LIM_W'(r_count) >= w_limit);
    assign w_wr_idx  = w_shift ? (r_count - CNT_W'(1)) : r_count;
    assign w_ins_nx  = r_ins + INTV_W'(1);

    // Chain of cells; the slot past the top reads as empty.
    assign w_hole[0]     = 1'b0;
    assign w_fp[DEPTH]   = '0;
    assign w_nc[DEPTH]   = '0;
    assign w_time[DEPTH] = '0;
    assign w_vld[DEPTH]  = 1'b0;
    assign w_occ[DEPTH]  = 1'b0;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        assign w_ctl[g].load_new = w_wr_en && (w_wr_idx == CNT_W'(g));
        assign w_ctl[g].shift    = w_shift;
        assign w_ctl[g].age      = w_age;
        assign w_ctl[g].pack     = w_pack;

        nrt_cell #(
            .KEY_WIDTH (KEY_WIDTH)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (w_ctl[g]),
            .i_key_fp   (r_req.fingerprint_digest[KEY_WIDTH-1:0]),
            .i_key_nc   (r_req.nonce_digest[KEY_WIDTH-1:0]),
            .i_key_time (r_req.insert_time),
            .i_now      (r_req.now_time),
            .i_ttl      (r_ttl),
            .i_nb_fp    (w_fp[g+1]),
            .i_nb_nc    (w_nc[g+1]),
            .i_nb_time  (w_time[g+1]),
            .i_nb_vld   (w_vld[g+1]),
            .i_nb_occ   (w_occ[g+1]),
            .i_hole     (w_hole[g]),
            .o_fp       (w_fp[g]),
            .o_nc       (w_nc[g]),
            .o_time     (w_time[g]),
            .o_vld      (w_vld[g]),
            .o_occ      (w_occ[g]),
            .o_hole     (w_hole[g+1]),
            .o_match    (w_match[g])
        );
    end

    assign w_any_match = |w_match;

    // State and request registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_count  <= '0;
            r_exp    <= '0;
            r_ins    <= '0;
            r_fresh  <= 1'b0;
            r_evict  <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_exp    <= n_exp;
            r_ins    <= n_ins;
            r_fresh  <= n_fresh;
            r_evict  <= n_evict;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rsp <= n_rsp;
        if (start && !busy) begin
            r_req <= i_req;
        end
    end

    // Sequencer: compare and insert, then age and pack the chain for a sweep.
    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_exp    = r_exp;
        n_ins    = r_ins;
        n_fresh  = r_fresh;
        n_evict  = r_evict;
        n_strobe = 1'b0;
        n_rsp    = r_rsp;
        w_wr_en  = 1'b0;
        w_shift  = 1'b0;
        w_age    = 1'b0;
        w_pack   = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_exp   = '0;
                    n_fresh = 1'b0;
                    n_evict = 1'b0;
                    n_state = (i_req.action == ACT_SWEEP) ? ST_AGE : ST_CMP;
                end
            end
            ST_CMP: begin
                if (w_any_match) begin
                    n_rsp    = '{fresh: 1'b0, evicted: 1'b0, expired_count: '0,
                                 entry_count: OCNT_W'(r_count)};
                    n_strobe = 1'b1;
                    n_state  = ST_IDLE;
                end else begin
                    // Drop the oldest when full, then append the new key.
                    w_wr_en = 1'b1;
                    w_shift = w_full;
                    n_count = w_full ? r_count : (r_count + CNT_W'(1));
                    n_fresh = 1'b1;
                    n_evict = w_full;
                    if (w_ins_nx >= r_intv) begin
                        n_ins   = '0;
                        n_state = ST_AGE;
                    end else begin
                        n_ins    = w_ins_nx;
                        n_rsp    = '{fresh: 1'b1, evicted: w_full, expired_count: '0,
                                     entry_count: OCNT_W'(n_count)};
                        n_strobe = 1'b1;
                        n_state  = ST_IDLE;
                    end
                end
            end
            ST_AGE: begin
                w_age   = 1'b1;
                n_state = ST_PACK;
            end
            ST_PACK: begin
                // Each cycle closes the lowest hole in the chain.
                if (w_hole[DEPTH]) begin
                    w_pack  = 1'b1;
                    n_count = r_count - CNT_W'(1);
                    n_exp   = r_exp + CNT_W'(1);
                end else begin
                    n_rsp    = '{fresh: r_fresh, evicted: r_evict,
                                 expired_count: OCNT_W'(r_exp),
                                 entry_count: OCNT_W'(r_count)};
                    n_strobe = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign busy     = (r_state != ST_IDLE);
    assign o_strobe = r_strobe;
    assign o_rsp    = r_rsp;

    // The response always comes back with the block ready for the next request.
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe |-> !busy)
        else $error("response strobe while busy");

    // Responses are never back to back.
    a_strobe_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe |=> !r_strobe)
        else $error("response strobe on consecutive cycles");

    // An accepted request always starts work.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("request accepted but block not busy");

    // The entry count never exceeds the chain length.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("entry count beyond depth");

    // An eviction only happens for a fresh key.
    a_evict_fresh: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && r_rsp.evicted) |-> r_rsp.fresh)
        else $error("eviction reported without insert");

endmodule

// ----- bench/nonce_replay_table_top_test.sv -----
`timescale 1ns / 100ps
// ============================================================================
// Nonce replay table testbench
// Drives check and sweep requests through the command port in random bursts.
// An in-bench model of the entry table predicts each response, and every
// response is compared field by field. The run covers several register
// settings: default, extreme and random values for TTL, capacity and sweep
// interval.
// ============================================================================
module nonce_replay_table_top_test;
    import nrt_pkg::*;

    localparam int TABLE_DEPTH = 64;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE_CYCLES = 4;
    // Long enough for a full-table sweep, so a stray response would show up.
    localparam int TAIL_CYCLES = TABLE_DEPTH + 16;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam logic [DIGEST_W-1:0] DIGEST_ONES = '1;
    localparam logic [TIME_W-1:0] TIME_MAX = '1;

    typedef struct packed {
        logic [DIGEST_W-1:0] fp;
        logic [DIGEST_W-1:0] nc;
    } t_key;

    // Block ports.
    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    t_req i_req = '0;
    logic o_strobe;
    t_rsp o_rsp;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = CFG_TTL;
    logic [TTL_W-1:0] i_cfg_data = '0;

    // Model of the entry table and its registers.
    logic [DIGEST_W-1:0] fp_cell [TABLE_DEPTH];
    logic [DIGEST_W-1:0] nc_cell [TABLE_DEPTH];
    logic [TIME_W-1:0] tm_cell [TABLE_DEPTH];
    int unsigned held;
    logic [INTV_W-1:0] ins_ctr;
    logic [TTL_W-1:0] ttl_reg;
    logic [CAP_W-1:0] cap_reg;
    logic [INTV_W-1:0] intv_reg;

    // Stimulus and checking state.
    t_req request_q[$];
    t_rsp verdict_q[$];
    t_key key_hist[$];
    logic [TIME_W-1:0] clk_ms;
    int unsigned burst_left = 0;
    int unsigned gap_left = 0;
    int unsigned queued_n = 0;
    int unsigned done_n = 0;
    int unsigned err_n = 0;
    int unsigned cycle_n = 0;
    int unsigned replay_n = 0;
    int unsigned evict_n = 0;
    int unsigned expired_n = 0;
    int unsigned fresh_n = 0;
    int unsigned peak_n = 0;
    int unsigned cfg_writes_n = 0;

    nonce_replay_table_top #(
        .DEPTH(TABLE_DEPTH),
        .KEY_WIDTH(DIGEST_W)
    ) uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_req(i_req),
        .o_strobe(o_strobe),
        .o_rsp(o_rsp),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Drop every entry older than the TTL and close up the survivors in age order.
    function automatic int unsigned expire_entries(logic [TIME_W-1:0] now);
        int unsigned keep = 0;
        int unsigned gone = 0;
        longint age;
        longint lim;
        lim = {32'd0, ttl_reg};
        for (int unsigned rd = 0; rd < held; rd++) begin
            age = $signed({16'd0, now}) - $signed({16'd0, tm_cell[rd]});
            if (age > lim) begin
                gone++;
            end else begin
                fp_cell[keep] = fp_cell[rd];
                nc_cell[keep] = nc_cell[rd];
                tm_cell[keep] = tm_cell[rd];
                keep++;
            end
        end
        held = keep;
        expired_n += gone;
        return gone;
    endfunction

    // Work out the response to one accepted request and update the table.
    function automatic t_rsp replay_verdict(t_req r);
        t_rsp v;
        bit hit;
        int unsigned lim;
        v = '0;
        hit = 1'b0;
        if (r.action == ACT_SWEEP) begin
            v.expired_count = OCNT_W'(expire_entries(r.now_time));
        end else begin
            for (int unsigned i = 0; i < held; i++) begin
                if (fp_cell[i] == r.fingerprint_digest && nc_cell[i] == r.nonce_digest)
                    hit = 1'b1;
            end
            if (hit) begin
                replay_n++;
            end else begin
                lim = (cap_reg == 0 || cap_reg > TABLE_DEPTH) ? TABLE_DEPTH : cap_reg;
                // Only the single oldest entry leaves, even if the limit is far below.
                if (held + 1 > lim) begin
                    for (int unsigned i = 1; i < held; i++) begin
                        fp_cell[i-1] = fp_cell[i];
                        nc_cell[i-1] = nc_cell[i];
                        tm_cell[i-1] = tm_cell[i];
                    end
                    held--;
                    v.evicted = 1'b1;
                    evict_n++;
                end
                if (held < TABLE_DEPTH) begin
                    fp_cell[held] = r.fingerprint_digest;
                    nc_cell[held] = r.nonce_digest;
                    tm_cell[held] = r.insert_time;
                    held++;
                end
                v.fresh = 1'b1;
                ins_ctr = ins_ctr + 1'b1;
                // An interval of zero behaves like one: every insert sweeps.
                if (ins_ctr >= intv_reg) begin
                    ins_ctr = '0;
                    v.expired_count = OCNT_W'(expire_entries(r.now_time));
                end
            end
        end
        v.entry_count = OCNT_W'(held);
        return v;
    endfunction

    // Driver: hold each request until accepted, in bursts with random gaps.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy)
                verdict_q = {verdict_q, replay_verdict(i_req)};
            if (start && busy) begin
                // The block has not taken the request yet.
            end else if (gap_left > 0) begin
                gap_left--;
                start <= 1'b0;
            end else if (request_q.size() > 0) begin
                i_req <= request_q[0];
                request_q.delete(0);
                start <= 1'b1;
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 12);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
                end
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: compare each response with the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            if (verdict_q.size() == 0) begin
                $error("response with no request outstanding: %p", o_rsp);
                err_n++;
            end else begin : b_check
                t_rsp want;
                want = verdict_q[0];
                verdict_q.delete(0);
                if (o_rsp.fresh !== want.fresh) begin
                    $error("fresh: expected %0d, actual %0d", want.fresh, o_rsp.fresh);
                    err_n++;
                end
                if (o_rsp.evicted !== want.evicted) begin
                    $error("evicted: expected %0d, actual %0d", want.evicted, o_rsp.evicted);
                    err_n++;
                end
                if (o_rsp.expired_count !== want.expired_count) begin
                    $error("expired_count: expected %0d, actual %0d",
                           want.expired_count, o_rsp.expired_count);
                    err_n++;
                end
                if (o_rsp.entry_count !== want.entry_count) begin
                    $error("entry_count: expected %0d, actual %0d",
                           want.entry_count, o_rsp.entry_count);
                    err_n++;
                end
                if (want.fresh)
                    fresh_n++;
                if (want.entry_count > peak_n)
                    peak_n = want.entry_count;
                done_n++;
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_n++;
        if (cycle_n >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic queue_request(logic act, logic [DIGEST_W-1:0] fp, logic [DIGEST_W-1:0] nc,
                                 logic [TIME_W-1:0] ins, logic [TIME_W-1:0] now);
        t_req r;
        r.action = act;
        r.fingerprint_digest = fp;
        r.nonce_digest = nc;
        r.insert_time = ins;
        r.now_time = now;
        request_q = {request_q, r};
        queued_n++;
    endtask

    // One random request: mostly checks, with replays of recent keys,
    // keys that match on one digest only, and some sweeps.
    task automatic queue_random_item(int unsigned step_max, int unsigned skew);
        int unsigned pick;
        int unsigned back;
        logic [63:0] wide;
        t_key k;
        logic [TIME_W-1:0] ins;
        logic [TIME_W-1:0] now;
        clk_ms = clk_ms + $urandom_range(0, step_max);
        now = clk_ms;
        if ($urandom_range(0, 49) == 0) begin
            wide = {$urandom, $urandom};
            now = wide[TIME_W-1:0];
        end
        ins = now - $urandom_range(0, skew);
        if ($urandom_range(0, 19) == 0)
            ins = now + $urandom_range(1, 100000);
        k.fp = {$urandom, $urandom};
        k.nc = {$urandom, $urandom};
        pick = $urandom_range(0, 99);
        if (pick < 36 && key_hist.size() > 0) begin
            back = $urandom_range(0, (key_hist.size() > 24) ? 24 : key_hist.size() - 1);
            if (pick < 30) begin
                k = key_hist[key_hist.size() - 1 - back];
            end else if (pick < 33) begin
                k.fp = key_hist[key_hist.size() - 1 - back].fp;
            end else begin
                k.nc = key_hist[key_hist.size() - 1 - back].nc;
            end
        end
        if (pick >= 90) begin
            queue_request(ACT_SWEEP, k.fp, k.nc, ins, now);
        end else begin
            queue_request(ACT_CHECK, k.fp, k.nc, ins, now);
            if (pick >= 30) begin
                key_hist = {key_hist, k};
                if (key_hist.size() > 96)
                    key_hist.delete(0);
            end
        end
    endtask

    // Wait until every queued request has its response checked.
    task automatic drain();
        while (done_n < queued_n)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Register write on the configuration channel, mirrored into the model.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [TTL_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_TTL: ttl_reg = data;
            CFG_CAP: cap_reg = data[CAP_W-1:0];
            CFG_INTV: intv_reg = data[INTV_W-1:0];
            default: ;
        endcase
        cfg_writes_n++;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // One phase: program all registers, then run random requests to completion.
    // Unused upper bits of the narrow registers carry random data.
    task automatic run_phase(logic [TTL_W-1:0] ttl, logic [CAP_W-1:0] cap,
                             logic [INTV_W-1:0] intv, logic [TIME_W-1:0] base,
                             int unsigned step_max, int unsigned skew, int unsigned n);
        logic [TTL_W-1:0] word;
        write_reg(CFG_TTL, ttl);
        word = $urandom;
        word[CAP_W-1:0] = cap;
        write_reg(CFG_CAP, word);
        word = $urandom;
        word[INTV_W-1:0] = intv;
        write_reg(CFG_INTV, word);
        clk_ms = base;
        repeat (n) queue_random_item(step_max, skew);
        drain();
    endtask

    initial begin
        logic [63:0] wide;
        held = 0;
        ins_ctr = '0;
        ttl_reg = TTL_RST;
        cap_reg = CAP_RST;
        intv_reg = INTV_RST;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed requests under the reset register values.
        queue_request(ACT_SWEEP, '0, '0, '0, '0);
        queue_request(ACT_CHECK, '0, '0, '0, '0);
        queue_request(ACT_CHECK, '0, '0, '0, '0);
        queue_request(ACT_CHECK, DIGEST_ONES, DIGEST_ONES, TIME_MAX, TIME_MAX);
        queue_request(ACT_CHECK, DIGEST_ONES, DIGEST_ONES, '0, '0);
        queue_request(ACT_CHECK, '0, DIGEST_ONES, '0, '0);
        queue_request(ACT_CHECK, DIGEST_ONES, '0, '0, '0);
        queue_request(ACT_CHECK, 64'h5555_AAAA_5555_AAAA, 64'hAAAA_5555_AAAA_5555,
                      48'd200000, '0);
        // An entry stamped exactly TTL ago survives; one more millisecond expires it.
        queue_request(ACT_SWEEP, DIGEST_ONES, DIGEST_ONES, TIME_MAX, 48'd60000);
        queue_request(ACT_SWEEP, '0, '0, '0, 48'd60001);
        queue_request(ACT_CHECK, '0, '0, 48'd60001, 48'd60001);
        queue_request(ACT_CHECK, '0, DIGEST_ONES, 48'd60001, 48'd60001);
        // Current time zero against the newest stamps: negative ages never expire.
        queue_request(ACT_SWEEP, '0, '0, '0, '0);
        queue_request(ACT_SWEEP, '0, '0, TIME_MAX, TIME_MAX);
        queue_request(ACT_CHECK, DIGEST_ONES, DIGEST_ONES, TIME_MAX, TIME_MAX);
        queue_request(ACT_CHECK, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210,
                      48'h8000_0000_0000, 48'h7FFF_FFFF_FFFF);
        queue_request(ACT_SWEEP, '0, '0, '0, TIME_MAX);
        drain();

        // Unused index, then fill past the full table with no expiry.
        wide = {$urandom, $urandom};
        write_reg(CFG_UNUSED, wide[TTL_W-1:0]);
        run_phase('1, 7'd0, 10'd1023, '0, 50, 200, 220);
        // Capacity lowered below the count: the count holds steady.
        run_phase('1, 7'd3, 10'd1023, 48'd20000, 50, 200, 60);
        // Short TTL, small capacity, frequent sweeps, high time values.
        wide = {$urandom, $urandom};
        run_phase(32'd300, 7'd5, 10'd3, {4'hF, wide[TIME_W-5:0]} - 48'd1000000,
                  40, 400, 180);
        // Zero TTL with a sweep after every insert.
        run_phase('0, 7'd1, 10'd1, 48'd5000, 3, 2, 120);
        // Capacity above the table depth and a zero interval.
        run_phase(32'd1000, 7'd127, 10'd0, 48'd100000, 20, 1500, 150);
        run_phase(32'd5000, 7'd64, 10'd17, 48'd7, 100, 6000, 200);
        // Random settings.
        wide = {$urandom, $urandom};
        run_phase(TTL_W'($urandom_range(0, 3000)), CAP_W'($urandom_range(2, 20)),
                  INTV_W'($urandom_range(1, 40)),
                  {2'b01, wide[TIME_W-3:0]}, 60, 3000, 150);

        while (verdict_q.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (verdict_q.size() != 0) begin
            $error("%0d predicted responses never arrived", verdict_q.size());
            err_n++;
        end

        $display("Checked %0d responses: %0d fresh, %0d replays, %0d evictions, %0d expired.",
                 done_n, fresh_n, replay_n, evict_n, expired_n);
        $display("Peak occupancy %0d entries over %0d register writes, %0d mismatches.",
                 peak_n, cfg_writes_n, err_n);
        if (err_n == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
